>>> rtl/lpa_pkg.sv
// ----------------------------------------------------------------------------
// lpa_pkg
// Shared types, constants and helpers of the length-prefixed to Annex B
// converter.
// ----------------------------------------------------------------------------
package lpa_pkg;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEVC_MODE    = 1'd1;

  localparam logic [2:0] PREFIX_BYTES_RST = 3'd4;
  localparam logic [2:0] PREFIX_BYTES_MIN = 3'd1;
  localparam logic [2:0] PREFIX_BYTES_MAX = 3'd4;

  localparam logic [7:0] FORBIDDEN_MASK = 8'h80;
  localparam logic [4:0] AVC_TYPE_MAX   = 5'd23;
  localparam logic [7:0] SC_ZERO        = 8'h00;
  localparam logic [7:0] SC_ONE         = 8'h01;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_FIRST,
    PH_SECOND,
    PH_BODY,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_START1,
    CMD_START2,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } cmd_t;

  // index of the final output byte of a command
  function automatic logic [2:0] cmd_end(input cmd_kind_t kind);
    logic [2:0] r;
    unique case (kind)
      CMD_BYTE:   r = 3'd0;
      CMD_START1: r = 3'd4;
      CMD_START2: r = 3'd5;
      CMD_ERROR:  r = 3'd0;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  // output byte at a given step of a command
  function automatic logic [7:0] cmd_byte(input cmd_t cmd, input logic [2:0] step);
    logic [7:0] r;
    r = SC_ZERO;
    unique case (cmd.kind)
      CMD_BYTE:   r = cmd.b1;
      CMD_ERROR:  r = SC_ZERO;
      CMD_START1: begin
        if (step == 3'd3) r = SC_ONE;
        else if (step == 3'd4) r = cmd.b1;
      end
      CMD_START2: begin
        if (step == 3'd3) r = SC_ONE;
        else if (step == 3'd4) r = cmd.b0;
        else if (step == 3'd5) r = cmd.b1;
      end
      default: r = SC_ZERO;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/lpa_in_if.sv
// ----------------------------------------------------------------------------
// lpa_in_if
// Input byte channel: valid/ready handshake with byte and last marker.
// ----------------------------------------------------------------------------
interface lpa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> rtl/lpa_out_if.sv
// ----------------------------------------------------------------------------
// lpa_out_if
// Output byte channel: valid/ready handshake with byte, last and failed.
// ----------------------------------------------------------------------------
interface lpa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       failed;

  modport source (output valid, output out_byte, output out_last, output failed,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input failed,
                  output ready);
endinterface

>>> rtl/lpa_front.sv
// ----------------------------------------------------------------------------
// lpa_front
// Parses length prefixes, checks NAL headers and queues output commands.
// ----------------------------------------------------------------------------
module lpa_front
  import lpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lpa_in_if.sink                in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [2:0]  prefix_bytes_r;
  logic        hevc_mode_r;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  pcount_r, pcount_nxt;
  logic [31:0] bleft_r, bleft_nxt;
  logic [7:0]  held_r, held_nxt;

  logic        acc;
  logic [7:0]  b;
  logic        last;
  logic [31:0] dec;
  logic [31:0] shifted;
  logic [2:0]  cnt;
  logic        fail_c;
  logic        emit_c;
  cmd_kind_t   kind_c;

  assign in_ch.ready = !q_full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign b    = in_ch.in_byte;
  assign last = in_ch.in_last;
  assign dec  = bleft_r - 32'd1;
  assign shifted = ((pcount_r == 2'd0) ? 32'd0 : {bleft_r[23:0], 8'h00}) | {24'd0, b};
  assign cnt  = {1'b0, pcount_r} + 3'd1;

  // classification of the current item
  always_comb begin
    fail_c = 1'b0;
    emit_c = 1'b0;
    kind_c = CMD_BYTE;
    unique case (phase_r)
      PH_PREFIX: begin
        if (prefix_bytes_r < PREFIX_BYTES_MIN || prefix_bytes_r > PREFIX_BYTES_MAX)
          fail_c = 1'b1;
        else if (cnt >= prefix_bytes_r)
          fail_c = (shifted == 32'd0) || last;
        else
          fail_c = last;
      end
      PH_FIRST: begin
        if (hevc_mode_r) begin
          fail_c = ((b & FORBIDDEN_MASK) != 8'd0) || (dec == 32'd0) || last;
        end else begin
          fail_c = ((b & FORBIDDEN_MASK) != 8'd0) || (b[4:0] == 5'd0) ||
                   (b[4:0] > AVC_TYPE_MAX) || (last && dec != 32'd0);
          emit_c = !fail_c;
          kind_c = CMD_START1;
        end
      end
      PH_SECOND: begin
        fail_c = (b[2:0] == 3'd0) || (last && dec != 32'd0);
        emit_c = !fail_c;
        kind_c = CMD_START2;
      end
      PH_BODY: begin
        fail_c = last && dec != 32'd0;
        emit_c = !fail_c;
        kind_c = CMD_BYTE;
      end
      PH_DISCARD: begin
        fail_c = last;
      end
      default: fail_c = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    pcount_nxt = pcount_r;
    bleft_nxt  = bleft_r;
    held_nxt   = held_r;
    if (acc) begin
      if (fail_c) begin
        pcount_nxt = 2'd0;
        bleft_nxt  = 32'd0;
        phase_nxt  = last ? PH_PREFIX : PH_DISCARD;
      end else begin
        unique case (phase_r)
          PH_PREFIX: begin
            bleft_nxt = shifted;
            if (cnt >= prefix_bytes_r) begin
              pcount_nxt = 2'd0;
              phase_nxt  = PH_FIRST;
            end else begin
              pcount_nxt = cnt[1:0];
            end
          end
          PH_FIRST: begin
            bleft_nxt = dec;
            if (hevc_mode_r) begin
              held_nxt  = b;
              phase_nxt = PH_SECOND;
            end else begin
              phase_nxt = (dec != 32'd0) ? PH_BODY : PH_PREFIX;
            end
          end
          PH_SECOND, PH_BODY: begin
            bleft_nxt = dec;
            phase_nxt = (dec != 32'd0) ? PH_BODY : PH_PREFIX;
          end
          PH_DISCARD: phase_nxt = PH_DISCARD;
          default:    phase_nxt = PH_PREFIX;
        endcase
      end
    end
  end

  // command output
  always_comb begin
    q_push      = acc && ((fail_c && last) || emit_c);
    q_cmd.kind  = fail_c ? CMD_ERROR : kind_c;
    q_cmd.b0    = held_r;
    q_cmd.b1    = b;
    q_cmd.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_bytes_r <= PREFIX_BYTES_RST;
      hevc_mode_r    <= 1'b0;
      phase_r        <= PH_PREFIX;
      pcount_r       <= 2'd0;
      bleft_r        <= 32'd0;
      held_r         <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_PREFIX_BYTES: prefix_bytes_r <= cfg_data;
          REG_HEVC_MODE:    hevc_mode_r    <= cfg_data[0];
          default:          ;
        endcase
      end
      phase_r  <= phase_nxt;
      pcount_r <= pcount_nxt;
      bleft_r  <= bleft_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

>>> rtl/lpa_cmdq.sv
// ----------------------------------------------------------------------------
// lpa_cmdq
// Small command queue between the parser and the output expander.
// ----------------------------------------------------------------------------
module lpa_cmdq
  import lpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_r, rptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + CMDQ_PTR_W'(1);
      if (do_pop)  rptr_r <= rptr_r + CMDQ_PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CMDQ_CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CMDQ_CNT_W'(1);
    end
  end

endmodule

>>> rtl/lpa_back.sv
// ----------------------------------------------------------------------------
// lpa_back
// Expands queued commands into output bytes, one per cycle unless out_ch stalls, with start codes.
// ----------------------------------------------------------------------------
module lpa_back
  import lpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  cmd_t     q_head,
  output logic     q_pop,
  lpa_out_if.source out_ch
);

  logic [2:0] step_r, step_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r;
  logic       olast_r;
  logic       ofail_r;
  logic       fire;
  logic       at_end;

  assign fire   = !q_empty && (!ovalid_r || out_ch.ready);
  assign at_end = (step_r == cmd_end(q_head.kind));
  assign q_pop  = fire && at_end;

  always_comb begin
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r;
    if (fire) begin
      ovalid_nxt = 1'b1;
      step_nxt   = at_end ? 3'd0 : step_r + 3'd1;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      obyte_r <= cmd_byte(q_head, step_r);
      olast_r <= at_end && q_head.last;
      ofail_r <= (q_head.kind == CMD_ERROR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 3'd0;
      ovalid_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_ch.valid    = ovalid_r;
  assign out_ch.out_byte = obyte_r;
  assign out_ch.out_last = olast_r;
  assign out_ch.failed   = ofail_r;

endmodule

>>> rtl/length_prefixed_to_annexb.sv
// ----------------------------------------------------------------------------
// length_prefixed_to_annexb
// Converts length-prefixed NAL units of an access unit to an Annex B stream.
// ----------------------------------------------------------------------------
// Bytes of one access unit enter on in_ch with the final byte marked by
// in_last; each NAL behind a 1 to 4 byte big-endian length prefix leaves on
// out_ch behind a 00 00 00 01 start code, after an AVC or HEVC header check
// chosen by hevc_mode. Any fault (zero length, truncation, bad header,
// prefix_bytes outside 1..4) voids the unit: bytes are swallowed up to in_last
// and a single result with failed and out_last set is sent. Payload bytes pass
// at one per cycle unless stalled; prefix bytes give no output. The header
// byte of an AVC NAL expands to 5 output bytes and the two header bytes of an
// HEVC NAL to 6, all sent at one byte per cycle by the output stage while
// out_ch is ready, so each NAL adds 4 start code bytes; a 4-entry command
// queue between the parser and the output stage absorbs these bursts; input is
// held off only while that queue is full. Configuration is written through
// cfg_we/cfg_idx/cfg_data: index 0 is prefix_bytes, index 1 is hevc_mode.
module length_prefixed_to_annexb
  import lpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lpa_in_if.sink                in_ch,
  lpa_out_if.source             out_ch
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_cmd, q_head;

  lpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  lpa_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  lpa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/length_prefixed_to_annexb_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_to_annexb_test
// Self-checking bench for the length-prefixed to Annex B converter. A
// directed table covers several prefix sizes, both header checks and many ways
// a unit can fail; random access units with mostly well-formed NALs follow over
// several register settings. Every accepted input byte is run through an in-bench
// converter; output items are checked in order against it or a pinned table result.
// ----------------------------------------------------------------------------
module length_prefixed_to_annexb_test;
  import lpa_pkg::*;

  localparam int PERIOD        = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_LIMIT_NS  = 2_400_000;
  localparam int PLAN_LEN      = 29;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       failed;
  } annexb_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } au_byte_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {PIN_MODEL, PIN_NONE, PIN_ONE} pin_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [7:0]            b;
    logic                  last;
    pin_t                  pin;
    annexb_t               res;
  } row_t;

  localparam annexb_t NO_RES  = '0;
  localparam annexb_t ERR_RES = '{SC_ZERO, 1'b1, 1'b1};

  localparam row_t PLAN [PLAN_LEN] = '{
    // reset settings: 4-byte prefix, avc
    '{ROW_ITEM, 1'b0, 3'd0, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h02, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h01, 1'b0, PIN_MODEL, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'hff, 1'b1, PIN_ONE, '{8'hff, 1'b1, 1'b0}},
    '{ROW_CFG, REG_PREFIX_BYTES, 3'd1, 8'h00, 1'b0, PIN_NONE, NO_RES},
    // zero length
    '{ROW_ITEM, 1'b0, 3'd0, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h55, 1'b1, PIN_ONE, ERR_RES},
    // prefix ends on the last byte
    '{ROW_ITEM, 1'b0, 3'd0, 8'h03, 1'b1, PIN_ONE, ERR_RES},
    // type 24
    '{ROW_ITEM, 1'b0, 3'd0, 8'h01, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h18, 1'b1, PIN_ONE, ERR_RES},
    // type 23, then payload cut short
    '{ROW_ITEM, 1'b0, 3'd0, 8'h03, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h17, 1'b0, PIN_MODEL, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h99, 1'b1, PIN_ONE, ERR_RES},
    '{ROW_CFG, REG_HEVC_MODE, 3'd1, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_CFG, REG_PREFIX_BYTES, 3'd2, 8'h00, 1'b0, PIN_NONE, NO_RES},
    // hevc nal of three bytes
    '{ROW_ITEM, 1'b0, 3'd0, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h03, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h40, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h01, 1'b0, PIN_MODEL, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'hab, 1'b1, PIN_ONE, '{8'hab, 1'b1, 1'b0}},
    // one-byte hevc nal
    '{ROW_ITEM, 1'b0, 3'd0, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h01, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h40, 1'b1, PIN_ONE, ERR_RES},
    // prefix cut short
    '{ROW_ITEM, 1'b0, 3'd0, 8'h00, 1'b1, PIN_ONE, ERR_RES},
    // prefix size out of range
    '{ROW_CFG, REG_PREFIX_BYTES, 3'd0, 8'h00, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h12, 1'b0, PIN_NONE, NO_RES},
    '{ROW_ITEM, 1'b0, 3'd0, 8'h34, 1'b1, PIN_ONE, ERR_RES}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpa_in_if  in_ch ();
  lpa_out_if out_ch ();

  length_prefixed_to_annexb dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // converter state and register copies
  phase_t      conv_phase;
  int unsigned pfx_seen;
  logic [31:0] nal_left;
  logic [7:0]  held_hdr;
  logic [2:0]  cur_pfx;
  logic        cur_hevc;

  annexb_t  step_out [$];
  annexb_t  annexb_q [$];
  au_byte_t unit_q [$];

  int mismatches = 0;
  int rx_hold = 0;
  bit calm = 1'b0;

  always begin
    #(PERIOD / 2) clk = 1'b1;
    #(PERIOD / 2) clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic void_unit(input logic last);
    pfx_seen = 0;
    nal_left = '0;
    if (last) begin
      conv_phase = PH_PREFIX;
      step_out.push_back(ERR_RES);
    end else begin
      conv_phase = PH_DISCARD;
    end
  endtask

  task automatic push_start_code();
    step_out.push_back('{SC_ZERO, 1'b0, 1'b0});
    step_out.push_back('{SC_ZERO, 1'b0, 1'b0});
    step_out.push_back('{SC_ZERO, 1'b0, 1'b0});
    step_out.push_back('{SC_ONE, 1'b0, 1'b0});
  endtask

  task automatic convert_byte(input logic [7:0] b, input logic last);
    logic [4:0] nal_type;
    nal_type = b[4:0];
    step_out.delete();
    case (conv_phase)
      PH_PREFIX: begin
        if (cur_pfx < PREFIX_BYTES_MIN || cur_pfx > PREFIX_BYTES_MAX) begin
          void_unit(last);
        end else begin
          nal_left = ((pfx_seen == 0) ? 32'd0 : (nal_left << 8)) | 32'(b);
          if (pfx_seen + 1 >= cur_pfx) begin
            pfx_seen = 0;
            if (nal_left == 0 || last) void_unit(last);
            else conv_phase = PH_FIRST;
          end else if (last) begin
            void_unit(last);
          end else begin
            pfx_seen = pfx_seen + 1;
          end
        end
      end
      PH_FIRST: begin
        nal_left = nal_left - 1;
        if (cur_hevc) begin
          if ((b & FORBIDDEN_MASK) != 0 || nal_left == 0 || last) begin
            void_unit(last);
          end else begin
            held_hdr = b;
            conv_phase = PH_SECOND;
          end
        end else if ((b & FORBIDDEN_MASK) != 0 || nal_type == 0 || nal_type > AVC_TYPE_MAX ||
                     (last && nal_left != 0)) begin
          void_unit(last);
        end else begin
          push_start_code();
          step_out.push_back('{b, last, 1'b0});
          conv_phase = (nal_left != 0) ? PH_BODY : PH_PREFIX;
        end
      end
      PH_SECOND: begin
        nal_left = nal_left - 1;
        if (b[2:0] == 3'd0 || (last && nal_left != 0)) begin
          void_unit(last);
        end else begin
          push_start_code();
          step_out.push_back('{held_hdr, 1'b0, 1'b0});
          step_out.push_back('{b, last, 1'b0});
          conv_phase = (nal_left != 0) ? PH_BODY : PH_PREFIX;
        end
      end
      PH_BODY: begin
        nal_left = nal_left - 1;
        if (last && nal_left != 0) begin
          void_unit(last);
        end else begin
          step_out.push_back('{b, last, 1'b0});
          if (nal_left == 0) conv_phase = PH_PREFIX;
        end
      end
      default: begin
        if (last) void_unit(last);
        else conv_phase = PH_DISCARD;
      end
    endcase
  endtask

  // entered and left at a falling edge
  task automatic feed_byte(input logic [7:0] b, input logic last, input pin_t pin,
                           input annexb_t pinned);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    in_ch.in_last = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    convert_byte(b, last);
    case (pin)
      PIN_MODEL: foreach (step_out[k]) annexb_q.push_back(step_out[k]);
      PIN_ONE:   annexb_q.push_back(pinned);
      default:   ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (annexb_q.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_PREFIX_BYTES) cur_pfx = val;
    else cur_hevc = val[0];
  endtask

  // one access unit: mostly clean nals, some with a single flaw
  task automatic build_unit(input logic [2:0] pfx, input logic mode);
    int flaw;
    int target;
    int nals;
    int len;
    int cut;
    logic [31:0] len_field;
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] b;
    unit_q.delete();
    if (pfx < PREFIX_BYTES_MIN || pfx > PREFIX_BYTES_MAX) begin
      repeat ($urandom_range(1, 6)) unit_q.push_back({8'($urandom), 1'b0});
    end else begin
      flaw = $urandom_range(0, 15);
      nals = $urandom_range(1, 3);
      target = $urandom_range(0, nals - 1);
      for (int n = 0; n < nals; n++) begin
        len = $urandom_range(mode ? 2 : 1, 6);
        len_field = 32'(len);
        h0 = {1'b0, 2'($urandom), 5'($urandom_range(1, 23))};
        if (mode) h0 = {1'b0, 7'($urandom)};
        h1 = {5'($urandom), 3'($urandom_range(1, 7))};
        if (n == target) begin
          case (flaw)
            0: begin
              len = 0;
              len_field = '0;
            end
            1: begin
              len = 1;
              len_field = 32'd1;
            end
            2: h0[7] = 1'b1;
            3: begin
              if (mode) h1[2:0] = 3'd0;
              else h0[4:0] = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(24, 31));
            end
            5: len_field = $urandom;
            default: ;
          endcase
        end
        for (int k = int'(pfx) - 1; k >= 0; k--) unit_q.push_back({len_field[8 * k +: 8], 1'b0});
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          if (i == 0) b = h0;
          else if (i == 1 && mode) b = h1;
          unit_q.push_back({b, 1'b0});
        end
      end
      if (flaw == 4) begin
        cut = $urandom_range(1, unit_q.size());
        unit_q = unit_q[0:cut - 1];
      end
    end
    unit_q[unit_q.size() - 1].last = 1'b1;
  endtask

  always @(negedge clk) begin
    if (calm) begin
      out_ch.ready = 1'b1;
      rx_hold = 0;
    end else if (rx_hold != 0) begin
      out_ch.ready = 1'b0;
      rx_hold = rx_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      rx_hold = $urandom_range(0, 7);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    annexb_t got;
    annexb_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.out_last, out_ch.failed};
      if (annexb_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: byte %02h last %0d failed %0d",
                   got.b, got.last, got.failed);
      end else begin
        want = annexb_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %02h last %0d failed %0d, got %02h %0d %0d",
                     want.b, want.last, want.failed, got.b, got.last, got.failed);
        end
      end
    end
  end

  initial begin : run
    int sent;
    logic [2:0] pfx_set;
    logic mode;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    conv_phase    = PH_PREFIX;
    pfx_seen      = 0;
    nal_left      = '0;
    held_hdr      = '0;
    cur_pfx       = PREFIX_BYTES_RST;
    cur_hevc      = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].val);
      end else begin
        feed_byte(PLAN[i].b, PLAN[i].last, PLAN[i].pin, PLAN[i].res);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin pfx_set = PREFIX_BYTES_MIN; mode = 1'b0; end
        1: begin pfx_set = PREFIX_BYTES_MAX; mode = 1'b1; end
        2: begin pfx_set = 3'd2; mode = 1'b1; end
        3: begin pfx_set = 3'd3; mode = 1'b0; end
        4: begin pfx_set = 3'($urandom_range(5, 7)); mode = 1'($urandom); end
        default: begin
          pfx_set = 3'($urandom_range(1, 4));
          mode = 1'($urandom);
          calm = 1'b1;
        end
      endcase
      write_reg(REG_PREFIX_BYTES, pfx_set);
      write_reg(REG_HEVC_MODE, {2'($urandom), mode});
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_unit(pfx_set, mode);
        foreach (unit_q[k]) begin
          feed_byte(unit_q[k].b, unit_q[k].last, PIN_MODEL, NO_RES);
          sent++;
        end
        if (!calm && $urandom_range(0, 7) == 0) drain();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
